### sv/dcpb_pkg.sv
// ----------------------------------------------------------------------------
// Display capture pixel blender package
// Payload types, configuration register map and pixel field constants shared
// by the capture blender modules.
// ----------------------------------------------------------------------------
package dcpb_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPTURE_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_FACTOR_A = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_FACTOR_B = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPTURE_SIZE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_BANK      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_OFFSET    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_SELECT  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_LCDC_MAP       = 3'd7;

    // Capture modes.
    localparam logic [1:0] MODE_SOURCE_A = 2'd0;
    localparam logic [1:0] MODE_SOURCE_B = 2'd1;

    // Blend weights are in sixteenths and clamp at one.
    localparam logic [4:0] EV_MAX     = 5'd16;
    localparam logic [4:0] CHAN_MAX   = 5'h1F;
    localparam logic [9:0] ROUND_HALF = 10'd8;

    typedef struct packed {
        logic [7:0]  scan_line;
        logic [7:0]  column;
        logic [31:0] pixel_two_d;
        logic [31:0] pixel_three_d;
        logic [15:0] pixel_b_vram;
        logic [15:0] pixel_b_fifo;
        logic        vram_b_mapped;
    } in_item_t;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [15:0] pixel_out;
        logic [7:0]  dirty_block;
    } out_item_t;

    typedef struct packed {
        logic [1:0] capture_mode;
        logic [4:0] blend_factor_a;
        logic [4:0] blend_factor_b;
        logic [1:0] capture_size;
        logic [1:0] dest_bank;
        logic [1:0] dest_offset;
        logic [1:0] source_select;
        logic [3:0] lcdc_map;
    } cfg_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] address;
        logic [7:0]  dirty;
    } addr_res_t;

endpackage

### sv/dcpb_addr.sv
// ----------------------------------------------------------------------------
// Capture address unit
// Clips the pixel against the capture area and the destination bank mapping,
// and forms the wrapped halfword address and the dirty block of the line.
// ----------------------------------------------------------------------------
module dcpb_addr (
    input  dcpb_pkg::cfg_t      cfg,
    input  logic [7:0]          scan_line,
    input  logic [7:0]          column,
    output dcpb_pkg::addr_res_t res
);
    import dcpb_pkg::*;

    logic        wide;
    logic        in_area;
    logic        bank_mapped;
    logic [15:0] line_base;
    logic [15:0] start;

    always_comb
    begin
        wide = (cfg.capture_size != 2'd0);
        // Height is 128 lines for the narrow size, otherwise 64 per size step,
        // so the line is inside when its top two bits are below the size.
        if (wide)
        begin
            in_area = (scan_line[7:6] < cfg.capture_size);
        end
        else
        begin
            in_area = !scan_line[7] && !column[7];
        end
        bank_mapped = cfg.lcdc_map[cfg.dest_bank];
        line_base   = wide ? {scan_line, 8'd0} : {1'b0, scan_line, 7'd0};
        start       = {cfg.dest_offset, 14'd0} + line_base;

        res.hit = in_area && bank_mapped;
        if (res.hit)
        begin
            res.address = start + {8'd0, column};
            res.dirty   = start[15:8];
        end
        else
        begin
            res.address = '0;
            res.dirty   = '0;
        end
    end

endmodule

### sv/dcpb_mix.sv
// ----------------------------------------------------------------------------
// Capture pixel mixer
// Selects sources A and B, converts A to 5:5:5 with alpha, and gives A, B or a
// blend of the two with clamped weights, rounding and saturation.
// ----------------------------------------------------------------------------
module dcpb_mix (
    input  dcpb_pkg::cfg_t     cfg,
    input  dcpb_pkg::in_item_t item,
    output logic [15:0]        pixel
);
    import dcpb_pkg::*;

    function automatic logic [4:0] mix_chan(
        input logic [4:0] ca,
        input logic [4:0] cb,
        input logic [4:0] eva,
        input logic [4:0] evb
    );
        logic [9:0] sum;
        logic [5:0] d;
        sum = {5'd0, ca} * {5'd0, eva} + {5'd0, cb} * {5'd0, evb} + ROUND_HALF;
        d   = sum[9:4];
        return (d > {1'b0, CHAN_MAX}) ? CHAN_MAX : d[4:0];
    endfunction

    logic [31:0] pa;
    logic [15:0] pb;
    logic        has_b;
    logic        aa;
    logic        ab;
    logic [4:0]  eva;
    logic [4:0]  evb;
    logic [4:0]  ra, ga, ba;
    logic [4:0]  rb, gb, bb;
    logic        ad;

    always_comb
    begin
        pa = cfg.source_select[0] ? item.pixel_three_d : item.pixel_two_d;
        if (cfg.source_select[1])
        begin
            pb    = item.pixel_b_fifo;
            has_b = 1'b1;
        end
        else
        begin
            pb    = item.pixel_b_vram;
            has_b = item.vram_b_mapped;
        end

        eva = (cfg.blend_factor_a > EV_MAX) ? EV_MAX : cfg.blend_factor_a;
        evb = (cfg.blend_factor_b > EV_MAX) ? EV_MAX : cfg.blend_factor_b;
        aa  = (pa[31:24] != 8'd0);
        ab  = has_b && pb[15];
        // A colour without its alpha takes no part in the blend.
        ra  = aa ? pa[5:1]   : 5'd0;
        ga  = aa ? pa[13:9]  : 5'd0;
        ba  = aa ? pa[21:17] : 5'd0;
        rb  = ab ? pb[4:0]   : 5'd0;
        gb  = ab ? pb[9:5]   : 5'd0;
        bb  = ab ? pb[14:10] : 5'd0;
        ad  = ((eva != 5'd0) && aa) || ((evb != 5'd0) && ab);

        case (cfg.capture_mode)
            MODE_SOURCE_A: pixel = {aa, pa[21:17], pa[13:9], pa[5:1]};
            MODE_SOURCE_B: pixel = has_b ? pb : 16'd0;
            default:
                pixel = {ad, mix_chan(ba, bb, eva, evb), mix_chan(ga, gb, eva, evb),
                         mix_chan(ra, rb, eva, evb)};
        endcase
    end

endmodule

### sv/display_capture_pixel_blender.sv
// ----------------------------------------------------------------------------
// Display capture pixel blender
// Takes one captured pixel per item and gives one destination write item:
// enable, wrapped halfword address, 5:5:5 pixel with alpha and dirty block.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, then in the result
// register.
// Throughput: one item per cycle; both registers advance together whenever
// the result register is empty or being taken.
// Reset clears the valid flags and all configuration registers to zero.
module display_capture_pixel_blender (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  dcpb_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output dcpb_pkg::out_item_t            out_data,
    input  logic                           cfg_we,
    input  logic [dcpb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dcpb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dcpb_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      out_valid_reg;
    logic      out_free;
    logic      in_load;
    logic      out_load;
    addr_res_t addr_res;
    logic [15:0] mixed_pixel;

    // Configuration write port.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAPTURE_MODE:   cfg_next.capture_mode   = cfg_data[1:0];
                CFG_BLEND_FACTOR_A: cfg_next.blend_factor_a = cfg_data[4:0];
                CFG_BLEND_FACTOR_B: cfg_next.blend_factor_b = cfg_data[4:0];
                CFG_CAPTURE_SIZE:   cfg_next.capture_size   = cfg_data[1:0];
                CFG_DEST_BANK:      cfg_next.dest_bank      = cfg_data[1:0];
                CFG_DEST_OFFSET:    cfg_next.dest_offset    = cfg_data[1:0];
                CFG_SOURCE_SELECT:  cfg_next.source_select  = cfg_data[1:0];
                CFG_LCDC_MAP:       cfg_next.lcdc_map       = cfg_data[3:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Handshake: the result register frees a slot when it is empty or taken,
    // and the input register moves on into it in the same cycle.
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;
    assign in_load  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    dcpb_addr u_addr (
        .cfg       (cfg_reg),
        .scan_line (in_item_reg.scan_line),
        .column    (in_item_reg.column),
        .res       (addr_res)
    );

    dcpb_mix u_mix (
        .cfg   (cfg_reg),
        .item  (in_item_reg),
        .pixel (mixed_pixel)
    );

    always_comb
    begin
        out_item_next.write_enable  = addr_res.hit;
        out_item_next.write_address = addr_res.address;
        out_item_next.pixel_out     = addr_res.hit ? mixed_pixel : 16'd0;
        out_item_next.dirty_block   = addr_res.dirty;
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_item_reg <= in_data;
        end
        if (out_load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // An item in the input register moves on whenever the result slot is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_free |=> out_valid_reg)
    else $error("item in input register was not moved to the result register");

    // A suppressed write carries an all-zero payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.write_enable |->
            out_item_reg.write_address == 16'd0 && out_item_reg.pixel_out == 16'd0 &&
            out_item_reg.dirty_block == 8'd0)
    else $error("suppressed write has a nonzero payload");

    // The column never carries into the line's block, so the address and the
    // dirty block share their top byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_item_reg.write_address[15:8] == out_item_reg.dirty_block)
    else $error("dirty block does not match the write address");

    // Input is refused only while the input register holds a stalled item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg)
    else $error("input refused with a free slot");

endmodule
